// File: sv/arpc_pkg.sv
// Package with the types, codes and defaults shared by the ARP responder and cache.
`default_nettype none

package arpc_pkg;

	// Default number of cache slots.
	localparam int CACHE_ENTRIES_DEF = 16;

	// ARP opcodes that the block acts on.
	localparam logic [15:0] OP_REQUEST = 16'd1;
	localparam logic [15:0] OP_REPLY   = 16'd2;

	// Item kinds.
	localparam logic KIND_PACKET = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	// Configuration register indexes.
	localparam logic CFG_OWN_IP  = 1'b0;
	localparam logic CFG_OWN_MAC = 1'b1;

	// Result actions.
	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_REPLY = 2'd1,
		ACT_HIT   = 2'd2,
		ACT_MISS  = 2'd3
	} action_t;

	// One input beat.
	typedef struct packed {
		logic        kind;
		logic [15:0] arp_op;
		logic [31:0] sender_ip;
		logic [47:0] sender_mac;
		logic [31:0] target_ip;
		logic [47:0] frame_source_mac;
		logic [31:0] query_ip;
	} in_t;

	// One result beat.
	typedef struct packed {
		action_t     action;
		logic [31:0] dest_ip;
		logic [47:0] dest_mac;
	} out_t;

	// Search token handed from cell to cell.
	typedef struct packed {
		logic        valid;
		logic        hit;
		logic        have_empty;
		logic [31:0] key;
		logic [47:0] mac;
	} scan_t;

	// Write broadcast to all cells.
	typedef struct packed {
		logic        en;
		logic [31:0] ip;
		logic [47:0] mac;
	} wr_t;

endpackage

`default_nettype wire

// File: sv/arpc_cell.sv
// One cache slot of the chain: holds an entry and advances the search token by one slot.
`default_nettype none

module arpc_cell #(
	parameter int IDX_W    = 4,
	parameter int CELL_IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  arpc_pkg::scan_t   tok_in,
	input  logic [IDX_W-1:0]  hit_idx_in,
	input  logic [IDX_W-1:0]  emp_idx_in,
	output arpc_pkg::scan_t   tok_out,
	output logic [IDX_W-1:0]  hit_idx_out,
	output logic [IDX_W-1:0]  emp_idx_out,
	input  arpc_pkg::wr_t     wr,
	input  logic [IDX_W-1:0]  wr_idx
);
	import arpc_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic [31:0]      ip_q;
	logic [47:0]      mac_q;
	scan_t            tok_nxt;
	scan_t            tok_q;
	logic [IDX_W-1:0] hit_idx_nxt;
	logic [IDX_W-1:0] emp_idx_nxt;
	logic [IDX_W-1:0] hit_idx_q;
	logic [IDX_W-1:0] emp_idx_q;

	// Entry storage; cleared at reset so every slot starts empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ip_q  <= '0;
			mac_q <= '0;
		end else if (wr.en && (wr_idx == MY_IDX)) begin
			ip_q  <= wr.ip;
			mac_q <= wr.mac;
		end
	end

	// The first matching slot wins the hit; the last empty slot seen is the highest one.
	always_comb begin
		tok_nxt     = tok_in;
		hit_idx_nxt = hit_idx_in;
		emp_idx_nxt = emp_idx_in;
		if (!tok_in.hit && (ip_q == tok_in.key)) begin
			tok_nxt.hit = 1'b1;
			tok_nxt.mac = mac_q;
			hit_idx_nxt = MY_IDX;
		end
		if (ip_q == '0) begin
			tok_nxt.have_empty = 1'b1;
			emp_idx_nxt        = MY_IDX;
		end
	end

	// Hand the token on to the next slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	always_ff @(posedge clk) begin
		hit_idx_q <= hit_idx_nxt;
		emp_idx_q <= emp_idx_nxt;
	end

	assign tok_out     = tok_q;
	assign hit_idx_out = hit_idx_q;
	assign emp_idx_out = emp_idx_q;

endmodule

`default_nettype wire

// File: sv/arp_responder_and_cache.sv
// Top level of the ARP responder and cache: controller, victim counter and the slot chain.
//
//   channel   ports                          handshake
//   ------    -----------------------------  ------------------------------------
//   input     start, busy, req               beat taken when start && !busy
//   result    done, rsp                      one beat, done high for one cycle
//   config    cfg_we, cfg_idx, cfg_data      register written when cfg_we is high
//
// Every item sends a search token down the chain of CACHE_ENTRIES slots, one slot
// per cycle; the accept is registered into the launch flag, the token then passes
// each slot register, and the result strobe is registered from the token at the tail.
// A new item is taken in the cycle the token leaves the chain, not while an item is
// still being searched. A learned entry is written into its slot as the token leaves.
// Reset empties all slots at once and zeroes the victim counter.
`default_nettype none

module arp_responder_and_cache #(
	parameter int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  arpc_pkg::in_t  req,
	output logic           done,
	output arpc_pkg::out_t rsp,
	input  logic           cfg_we,
	input  logic           cfg_idx,
	input  logic [47:0]    cfg_data
);
	import arpc_pkg::*;

	localparam int               IDX_W    = $clog2(CACHE_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	state_t           state_q;
	logic             launch_q;
	in_t              item_q;
	logic [IDX_W-1:0] ctr_q;
	logic [IDX_W-1:0] victim_q;
	logic [31:0]      own_ip_q;
	logic             done_q;
	out_t             rsp_q;
	out_t             rsp_nxt;
	logic             accept;
	wr_t              wr;
	logic [IDX_W-1:0] wr_idx;

	scan_t            tok     [CACHE_ENTRIES+1];
	logic [IDX_W-1:0] hit_idx [CACHE_ENTRIES+1];
	logic [IDX_W-1:0] emp_idx [CACHE_ENTRIES+1];

	scan_t            tail;

	assign tail   = tok[CACHE_ENTRIES];
	assign busy   = (state_q == S_SCAN) && !tail.valid;
	assign accept = start && !busy;

	// Configuration: only the own IP takes part in any result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q <= '0;
		end else if (cfg_we && (cfg_idx == CFG_OWN_IP)) begin
			own_ip_q <= cfg_data[31:0];
		end
	end

	// Sequencer and victim counter, which steps once per accepted item and wraps after the last slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			launch_q <= 1'b0;
			ctr_q    <= '0;
		end else begin
			launch_q <= accept;
			if (accept) begin
				state_q <= S_SCAN;
				ctr_q   <= (ctr_q == LAST_IDX) ? '0 : ctr_q + 1'b1;
			end else begin
				unique case (state_q)
					S_IDLE: state_q <= S_IDLE;
					S_SCAN: if (tail.valid) state_q <= S_IDLE;
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q   <= req;
			victim_q <= ctr_q;
		end
	end

	// Head of the chain: a fresh token keyed on the query or sender IP.
	assign tok[0].valid      = launch_q;
	assign tok[0].hit        = 1'b0;
	assign tok[0].have_empty = 1'b0;
	assign tok[0].key        = (item_q.kind == KIND_LOOKUP) ? item_q.query_ip
	                                                        : item_q.sender_ip;
	assign tok[0].mac        = '0;
	assign hit_idx[0]        = '0;
	assign emp_idx[0]        = '0;

	for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
		arpc_cell #(
			.IDX_W    (IDX_W),
			.CELL_IDX (g)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.tok_in      (tok[g]),
			.hit_idx_in  (hit_idx[g]),
			.emp_idx_in  (emp_idx[g]),
			.tok_out     (tok[g+1]),
			.hit_idx_out (hit_idx[g+1]),
			.emp_idx_out (emp_idx[g+1]),
			.wr          (wr),
			.wr_idx      (wr_idx)
		);
	end

	// Learning a reply: update a match, else fill the highest empty slot, else evict.
	always_comb begin
		wr.en  = tail.valid && (item_q.kind == KIND_PACKET) && (item_q.arp_op == OP_REPLY);
		wr.ip  = item_q.sender_ip;
		wr.mac = item_q.sender_mac;
		priority if (tail.hit) begin
			wr_idx = hit_idx[CACHE_ENTRIES];
		end else if (tail.have_empty) begin
			wr_idx = emp_idx[CACHE_ENTRIES];
		end else begin
			wr_idx = victim_q;
		end
	end

	// Result of the finished item.
	always_comb begin
		rsp_nxt.action   = ACT_NONE;
		rsp_nxt.dest_ip  = '0;
		rsp_nxt.dest_mac = '0;
		if (item_q.kind == KIND_LOOKUP) begin
			rsp_nxt.dest_ip = item_q.query_ip;
			if (tail.hit) begin
				rsp_nxt.action   = ACT_HIT;
				rsp_nxt.dest_mac = tail.mac;
			end else begin
				rsp_nxt.action = ACT_MISS;
			end
		end else if ((item_q.arp_op == OP_REQUEST) && (item_q.target_ip == own_ip_q)) begin
			rsp_nxt.action   = ACT_REPLY;
			rsp_nxt.dest_ip  = item_q.sender_ip;
			rsp_nxt.dest_mac = item_q.frame_source_mac;
		end
	end

	// Output register: one result beat per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= tail.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tail.valid) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// An accepted item keeps the block busy until its token leaves the chain.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("block not busy after accepting an item");

	// A token only reaches the tail while an item is being searched.
	a_tail_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |-> (state_q == S_SCAN))
		else $error("token left the chain outside a search");

	// Each result beat follows a search.
	a_done_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == S_SCAN))
		else $error("result beat without a search");

	// The victim counter stays within the slots.
	a_ctr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctr_q <= LAST_IDX)
		else $error("victim counter out of range");

endmodule

`default_nettype wire
